[hdl/vn_pkg.sv]
`default_nettype none
package vn_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_WIDTH_DEF  = 24;
  localparam int SUM_W         = 64;
  localparam int ROOT_W        = 32;
  localparam int NLANE         = 4;

endpackage
`default_nettype wire

[hdl/vector_normalise_core.sv]
`default_nettype none
// Channel  | Ports                                    | Direction
// in       | in_valid, in_stall, in_{x,y,z,w}_in       | request in
// out      | out_valid, out_stall, out_{x,y,z,w}_out,  | request out
//          | out_zero_length                          |
// One request per cycle while the output is not stalled. KB = clog2(KMAX+1)
// sizes the scale chain; QW = max(IN_WIDTH, FRAC_BITS+2) sizes the divider
// chain (one quotient bit per cell); root cells give one root bit each.
// Reset clears only valid bits. A stalled output freezes the whole pipeline.
module vector_normalise_core #(
  parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF,
  parameter int IN_WIDTH  = vn_pkg::IN_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [IN_WIDTH-1:0] in_x_in,
  input  wire logic signed [IN_WIDTH-1:0] in_y_in,
  input  wire logic signed [IN_WIDTH-1:0] in_z_in,
  input  wire logic signed [IN_WIDTH-1:0] in_w_in,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [FRAC_BITS+1:0]     out_x_out,
  output logic signed [FRAC_BITS+1:0]     out_y_out,
  output logic signed [FRAC_BITS+1:0]     out_z_out,
  output logic signed [IN_WIDTH-1:0]      out_w_out,
  output logic                            out_zero_length
);

  localparam int W    = IN_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int NL   = vn_pkg::NLANE;
  localparam int SW   = vn_pkg::SUM_W;
  localparam int RW   = vn_pkg::ROOT_W;
  localparam int KMAX = SW - W - F;
  localparam int KB   = $clog2(KMAX + 1);
  localparam int QW   = (W > F + 2) ? W : F + 2;
  localparam int OW   = F + 2;
  localparam int HW   = SW - QW;
  localparam int SHW  = $clog2(SW);
  localparam int SDA  = NL * W + NL + 1;
  localparam int SDB  = KB + SDA;
  localparam int SDC  = 2 * NL + 1;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // input stage
  logic                  v0_r;
  logic [NL-1:0][W-1:0]  mag0_r;
  logic [NL-1:0]         neg0_r;
  logic                  zero0_r;
  logic [NL-1:0][W-1:0]  raw;

  assign raw = {in_w_in, in_z_in, in_y_in, in_x_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        neg0_r[i] <= raw[i][W-1];
        mag0_r[i] <= raw[i][W-1] ? (~raw[i] + W'(1)) : raw[i];
      end
      zero0_r <= (in_x_in == '0) && (in_y_in == '0) && (in_z_in == '0);
    end
  end

  // squares
  logic                   v1_r;
  logic [2:0][2*W-1:0]    sq1_r;
  logic [SDA-1:0]         sd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq1_r[i] <= mag0_r[i] * mag0_r[i];
      end
      sd1_r <= {zero0_r, neg0_r, mag0_r};
    end
  end

  // sum
  logic           v2_r;
  logic [SW-1:0]  s2_r;
  logic [SDA-1:0] sd2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r  <= SW'(sq1_r[0]) + SW'(sq1_r[1]) + SW'(sq1_r[2]);
      sd2_r <= sd1_r;
    end
  end

  // scale chain
  logic [KB:0]            nv;
  logic [KB:0][SW-1:0]    ns;
  logic [KB:0][KB-1:0]    nk;
  logic [KB:0][SDA-1:0]   nsd;

  assign nv[0]  = v2_r;
  assign ns[0]  = s2_r;
  assign nk[0]  = '0;
  assign nsd[0] = sd2_r;

  for (genvar j = 0; j < KB; j++) begin : g_norm
    vn_norm_cell #(.KB(KB), .KMAX(KMAX), .P(1 << (KB - 1 - j)), .SDW(SDA)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .vld_i(nv[j]), .s_i(ns[j]), .k_i(nk[j]), .side_i(nsd[j]),
      .vld_r(nv[j+1]), .s_r(ns[j+1]), .k_r(nk[j+1]), .side_r(nsd[j+1])
    );
  end

  // root chain
  logic [RW:0]              rv;
  logic [RW:0][SW-1:0]      rs;
  logic [RW:0][RW:0]        rrem;
  logic [RW:0][RW-1:0]      rroot;
  logic [RW:0][SDB-1:0]     rsd;

  assign rv[0]    = nv[KB];
  assign rs[0]    = ns[KB];
  assign rrem[0]  = '0;
  assign rroot[0] = '0;
  assign rsd[0]   = {nk[KB], nsd[KB]};

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    vn_sqrt_cell #(.SDW(SDB)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .vld_i(rv[j]), .s_i(rs[j]), .rem_i(rrem[j]), .root_i(rroot[j]), .side_i(rsd[j]),
      .vld_r(rv[j+1]), .s_r(rs[j+1]), .rem_r(rrem[j+1]), .root_r(rroot[j+1]),
      .side_r(rsd[j+1])
    );
  end

  // divider setup
  logic [NL-1:0][W-1:0]  smag;
  logic [NL-1:0]         sneg;
  logic                  szero;
  logic [KB-1:0]         sk;
  logic [SHW-1:0]        sh;
  logic [NL-1:0][SW-1:0] dvd;
  logic [NL-1:0][HW-1:0] hi;

  assign {sk, szero, sneg, smag} = rsd[RW];
  assign sh = SHW'(F) + SHW'(sk);

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      dvd[i] = SW'(smag[i]) << sh;
      hi[i]  = dvd[i][SW-1:QW];
    end
  end

  logic                   v3_r;
  logic [RW-1:0]          len3_r;
  logic [NL-1:0][RW-1:0]  rem3_r;
  logic [NL-1:0][QW-1:0]  dl3_r;
  logic [SDC-1:0]         sd3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= rv[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len3_r <= rroot[RW];
      for (int i = 0; i < NL; i++) begin
        rem3_r[i]   <= hi[i][RW-1:0];
        dl3_r[i]    <= dvd[i][QW-1:0];
        sd3_r[NL+i] <= hi[i] >= HW'(rroot[RW]);
      end
      sd3_r[NL-1:0]  <= sneg;
      sd3_r[2*NL]    <= szero;
    end
  end

  // divider chain
  logic [QW:0]                     dv;
  logic [QW:0][RW-1:0]             dlen;
  logic [QW:0][NL-1:0][RW-1:0]     drem;
  logic [QW:0][NL-1:0][QW-1:0]     ddl;
  logic [QW:0][NL-1:0][QW-1:0]     dq;
  logic [QW:0][SDC-1:0]            dsd;

  assign dv[0]   = v3_r;
  assign dlen[0] = len3_r;
  assign drem[0] = rem3_r;
  assign ddl[0]  = dl3_r;
  assign dq[0]   = '0;
  assign dsd[0]  = sd3_r;

  for (genvar j = 0; j < QW; j++) begin : g_div
    vn_div_cell #(.QW(QW), .SDW(SDC)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .vld_i(dv[j]), .len_i(dlen[j]), .rem_i(drem[j]), .dl_i(ddl[j]), .q_i(dq[j]),
      .side_i(dsd[j]),
      .vld_r(dv[j+1]), .len_r(dlen[j+1]), .rem_r(drem[j+1]), .dl_r(ddl[j+1]),
      .q_r(dq[j+1]), .side_r(dsd[j+1])
    );
  end

  // clamp, sign and output register
  logic [NL-1:0]         fneg;
  logic [NL-1:0]         fovf;
  logic                  fzero;
  logic [2:0][OW-1:0]    umag;
  logic [2:0][OW-1:0]    uval;
  logic [QW-1:0]         wlim;
  logic [QW-1:0]         wq;
  logic [W-1:0]          wval;

  assign fneg  = dsd[QW][NL-1:0];
  assign fovf  = dsd[QW][2*NL-1:NL];
  assign fzero = dsd[QW][2*NL];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fovf[i] || (dq[QW][i] > (QW'(1) << F))) begin
        umag[i] = OW'(1) << F;
      end else begin
        umag[i] = OW'(dq[QW][i]);
      end
      uval[i] = fneg[i] ? (~umag[i] + OW'(1)) : umag[i];
    end
    wlim = fneg[3] ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
    wq   = (fovf[3] || (dq[QW][3] > wlim)) ? wlim : dq[QW][3];
    wval = fneg[3] ? (~W'(wq) + W'(1)) : W'(wq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_out       <= fzero ? '0 : uval[0];
      out_y_out       <= fzero ? '0 : uval[1];
      out_z_out       <= fzero ? '0 : uval[2];
      out_w_out       <= fzero ? '0 : wval;
      out_zero_length <= fzero;
    end
  end

endmodule
`default_nettype wire

[hdl/vn_norm_cell.sv]
`default_nettype none
module vn_norm_cell #(
  parameter int KB   = 5,
  parameter int KMAX = 24,
  parameter int P    = 1,
  parameter int SDW  = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     vld_i,
  input  wire logic [vn_pkg::SUM_W-1:0] s_i,
  input  wire logic [KB-1:0]            k_i,
  input  wire logic [SDW-1:0]           side_i,
  output logic                          vld_r,
  output logic [vn_pkg::SUM_W-1:0]      s_r,
  output logic [KB-1:0]                 k_r,
  output logic [SDW-1:0]                side_r
);

  logic                     fits;
  logic [vn_pkg::SUM_W-1:0] s_nxt;
  logic [KB-1:0]            k_nxt;

  always_comb begin
    fits = (({1'b0, k_i} + (KB+1)'(P)) <= (KB+1)'(KMAX)) &&
           (s_i[vn_pkg::SUM_W-1 -: 2*P] == '0);
    s_nxt = fits ? (s_i << (2*P)) : s_i;
    k_nxt = fits ? (k_i + KB'(P)) : k_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_nxt;
      k_r    <= k_nxt;
      side_r <= side_i;
    end
  end

endmodule
`default_nettype wire

[hdl/vn_sqrt_cell.sv]
`default_nettype none
module vn_sqrt_cell #(
  parameter int SDW = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      vld_i,
  input  wire logic [vn_pkg::SUM_W-1:0]  s_i,
  input  wire logic [vn_pkg::ROOT_W:0]   rem_i,
  input  wire logic [vn_pkg::ROOT_W-1:0] root_i,
  input  wire logic [SDW-1:0]            side_i,
  output logic                           vld_r,
  output logic [vn_pkg::SUM_W-1:0]       s_r,
  output logic [vn_pkg::ROOT_W:0]        rem_r,
  output logic [vn_pkg::ROOT_W-1:0]      root_r,
  output logic [SDW-1:0]                 side_r
);

  localparam int TW = vn_pkg::ROOT_W + 3;

  logic [TW-1:0]              trial;
  logic [TW-1:0]              tst;
  logic                       ge;
  logic [vn_pkg::ROOT_W:0]    rem_nxt;
  logic [vn_pkg::ROOT_W-1:0]  root_nxt;

  always_comb begin
    trial    = {rem_i, s_i[vn_pkg::SUM_W-1 -: 2]};
    tst      = TW'({root_i, 2'b01});
    ge       = trial >= tst;
    rem_nxt  = ge ? (vn_pkg::ROOT_W+1)'(trial - tst) : (vn_pkg::ROOT_W+1)'(trial);
    root_nxt = {root_i[vn_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_i << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

endmodule
`default_nettype wire

[hdl/vn_div_cell.sv]
`default_nettype none
module vn_div_cell #(
  parameter int QW  = 24,
  parameter int SDW = 9
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         en,
  input  wire logic                                         vld_i,
  input  wire logic [vn_pkg::ROOT_W-1:0]                    len_i,
  input  wire logic [vn_pkg::NLANE-1:0][vn_pkg::ROOT_W-1:0] rem_i,
  input  wire logic [vn_pkg::NLANE-1:0][QW-1:0]             dl_i,
  input  wire logic [vn_pkg::NLANE-1:0][QW-1:0]             q_i,
  input  wire logic [SDW-1:0]                               side_i,
  output logic                                              vld_r,
  output logic [vn_pkg::ROOT_W-1:0]                         len_r,
  output logic [vn_pkg::NLANE-1:0][vn_pkg::ROOT_W-1:0]      rem_r,
  output logic [vn_pkg::NLANE-1:0][QW-1:0]                  dl_r,
  output logic [vn_pkg::NLANE-1:0][QW-1:0]                  q_r,
  output logic [SDW-1:0]                                    side_r
);

  logic [vn_pkg::NLANE-1:0][vn_pkg::ROOT_W:0]   trial;
  logic [vn_pkg::NLANE-1:0]                     ge;
  logic [vn_pkg::NLANE-1:0][vn_pkg::ROOT_W-1:0] rem_nxt;
  logic [vn_pkg::NLANE-1:0][QW-1:0]             q_nxt;

  always_comb begin
    for (int i = 0; i < vn_pkg::NLANE; i++) begin
      trial[i]   = {rem_i[i], dl_i[i][QW-1]};
      ge[i]      = trial[i] >= {1'b0, len_i};
      rem_nxt[i] = ge[i] ? vn_pkg::ROOT_W'(trial[i] - {1'b0, len_i})
                         : vn_pkg::ROOT_W'(trial[i]);
      q_nxt[i]   = {q_i[i][QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r  <= len_i;
      side_r <= side_i;
      for (int i = 0; i < vn_pkg::NLANE; i++) begin
        rem_r[i] <= rem_nxt[i];
        dl_r[i]  <= dl_i[i] << 1;
        q_r[i]   <= q_nxt[i];
      end
    end
  end

endmodule
`default_nettype wire
